>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Both sample on clk and stay quiet in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds.
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

>>> rtl/tpc_pkg.sv
package tpc_pkg;

  // Fixed field widths
  localparam int Q_W        = 32;  // Q16.16 component
  localparam int PROD_W     = 64;  // component times normal
  localparam int DOT_W      = 66;  // sum of three products
  localparam int DIFF_W     = 67;  // difference of two dot products
  localparam int REM_W      = 69;  // divider remainder, room for one shift
  localparam int FRAC_W     = 33;  // edge fraction, unsigned Q1.32
  localparam int DIV_PER    = 3;   // divider steps per pipeline stage
  localparam int DIV_STAGES = FRAC_W / DIV_PER;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Z       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_CONSTANT = 2'd3;

  localparam logic [Q_W-1:0] NORMAL_Z_RESET = 32'h0001_0000;

  typedef logic signed [Q_W-1:0]    q16_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [DOT_W-1:0]  dot_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic [REM_W-1:0]         rem_t;
  typedef logic [FRAC_W-1:0]        frac_t;

  // Component 0..3 is x, y, z, w
  typedef q16_t [3:0] corner_t;
  typedef corner_t [2:0] tri_t;

  typedef enum logic [1:0] {
    CASE_NONE,
    CASE_ALL,
    CASE_ONE,
    CASE_SPLIT
  } clip_case_t;

  typedef struct packed {
    q16_t corner0_x;
    q16_t corner0_y;
    q16_t corner0_z;
    q16_t corner0_w;
    q16_t corner1_x;
    q16_t corner1_y;
    q16_t corner1_z;
    q16_t corner1_w;
    q16_t corner2_x;
    q16_t corner2_y;
    q16_t corner2_z;
    q16_t corner2_w;
  } in_item_t;

  typedef struct packed {
    q16_t       out_x;
    q16_t       out_y;
    q16_t       out_z;
    q16_t       out_w;
    logic       triangle_number;
    logic [1:0] corner_number;
    logic       last;
  } out_item_t;

endpackage

>>> rtl/tpc_div.sv
// Pipelined restoring divider: t = num / den as unsigned Q1.32, zero when
// den is not positive or num is negative.
module tpc_div (
  input  logic           clk,
  input  logic           en,
  input  tpc_pkg::diff_t num,
  input  tpc_pkg::diff_t den,
  output tpc_pkg::frac_t t
);

  typedef struct packed {
    tpc_pkg::rem_t  rem;
    tpc_pkg::rem_t  den;
    tpc_pkg::frac_t quo;
    logic           zero;
  } div_stage_t;

  div_stage_t stg_r [tpc_pkg::DIV_STAGES];
  div_stage_t seed;

  // One quotient bit: shift (except the integer bit), compare, subtract
  function automatic div_stage_t div_step(div_stage_t s, logic shift);
    div_stage_t r;
    r = s;
    if (shift) begin
      r.rem = {r.rem[tpc_pkg::REM_W-2:0], 1'b0};
      r.quo = {r.quo[tpc_pkg::FRAC_W-2:0], 1'b0};
    end
    if (r.rem >= r.den) begin
      r.rem    = r.rem - r.den;
      r.quo[0] = 1'b1;
    end
    return r;
  endfunction

  // Load the operands
  always_comb begin
    seed.rem  = tpc_pkg::REM_W'($unsigned(num));
    seed.den  = tpc_pkg::REM_W'($unsigned(den));
    seed.quo  = '0;
    seed.zero = (den <= 0) || (num < 0);
  end

  for (genvar st = 0; st < tpc_pkg::DIV_STAGES; st++) begin : g_stage
    div_stage_t cur;
    div_stage_t stage_nxt;

    if (st == 0) begin : g_first
      assign cur = seed;
    end else begin : g_next
      assign cur = stg_r[st-1];
    end

    // Resolve a few quotient bits per stage
    always_comb begin
      stage_nxt = cur;
      for (int j = 0; j < tpc_pkg::DIV_PER; j++) begin
        stage_nxt = div_step(stage_nxt, (st * tpc_pkg::DIV_PER + j) != 0);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg_r[st] <= stage_nxt;
      end
    end
  end

  assign t = stg_r[tpc_pkg::DIV_STAGES-1].zero ? '0 : stg_r[tpc_pkg::DIV_STAGES-1].quo;

endmodule

>>> rtl/triangle_plane_clipper.sv
// Clips one triangle per request against the half-space n.p >= k and sends the
// surviving corners out one per request: none, three (one triangle) or six (two
// triangles), with last set on the final corner. The pipe advances only when
// the held record has sent its last corner or had none; the output port, one
// corner per cycle while out_stall is low, sets that pace. Stages to the first
// corner are: multiply, dot sum, three sort stages, classify, 11 divider stages
// (three quotient bits each), two interpolation stages, record and output
// register. Configuration must be written only while the block is empty.
`include "assert_macros.svh"

module triangle_plane_clipper (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  tpc_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output tpc_pkg::out_item_t                  out_data,
  input  logic                                cfg_we,
  input  logic [tpc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tpc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam logic [2:0] IDX_LAST_ONE   = 3'd2;
  localparam logic [2:0] IDX_LAST_SPLIT = 3'd5;
  localparam logic [2:0] IDX_SECOND     = 3'd3;

  typedef struct packed {
    tpc_pkg::tri_t    pts;
    tpc_pkg::dot_t [2:0] d;
  } sort_t;

  typedef struct packed {
    tpc_pkg::tri_t       pts;
    tpc_pkg::clip_case_t code;
  } carry_t;

  typedef struct packed {
    tpc_pkg::tri_t       pts;
    tpc_pkg::corner_t    e0;
    tpc_pkg::corner_t    e1;
    tpc_pkg::clip_case_t code;
  } rec_t;

  // Configuration
  tpc_pkg::q16_t            nx_r, ny_r, nz_r;
  logic signed [63:0]       k_r;

  // Pipeline registers
  logic                     en;
  logic                     s1_v_r;
  tpc_pkg::tri_t            s1_pts_r;
  tpc_pkg::prod_t           s1_prod_r [3][3];
  tpc_pkg::tri_t            pts_in;
  tpc_pkg::prod_t           prod_nxt [3][3];

  logic                     srt_v_r [4];
  sort_t                    srt_r [4];
  sort_t                    srt_nxt [4];

  logic                     cls_v_r;
  carry_t                   cls_r;
  carry_t                   cls_nxt;
  tpc_pkg::diff_t           num_r [2];
  tpc_pkg::diff_t           den_r [2];
  tpc_pkg::diff_t           num_nxt [2];
  tpc_pkg::diff_t           den_nxt [2];
  tpc_pkg::dot_t            k_ext, d0, d1, d2;
  logic                     one_above;

  logic                     car_v_r [tpc_pkg::DIV_STAGES];
  carry_t                   car_r [tpc_pkg::DIV_STAGES];
  tpc_pkg::frac_t           t_edge [2];

  logic                     m1_v_r;
  carry_t                   m1_r;
  logic [32:0]              m1_mag_r [2][4];
  logic                     m1_neg_r [2][4];
  tpc_pkg::frac_t           m1_t_r [2];
  logic [32:0]              mag_nxt [2][4];
  logic                     neg_nxt [2][4];

  logic                     m2_v_r;
  carry_t                   m2_r;
  logic [64:0]              m2_prod_r [2][4];
  logic                     m2_hi_r [2][4];
  logic                     m2_neg_r [2][4];
  tpc_pkg::frac_t           m2_t_r [2];

  // Serializer
  logic                     rec_valid_r;
  rec_t                     rec_r;
  rec_t                     rec_nxt;
  logic [2:0]               idx_r;
  logic                     out_valid_r;
  tpc_pkg::out_item_t       out_r;
  tpc_pkg::out_item_t       out_nxt;
  tpc_pkg::corner_t         sel;
  logic                     sel_last;
  logic                     out_ld;
  logic                     rec_done;

  // Edge endpoints: edge 0 runs from the lowest corner, edge 1 ends at the top
  function automatic tpc_pkg::q16_t end_a(tpc_pkg::tri_t p, logic one, int e, int j);
    if (e == 0) begin
      return p[0][j];
    end
    return one ? p[1][j] : p[0][j];
  endfunction

  function automatic tpc_pkg::q16_t end_c(tpc_pkg::tri_t p, logic one, int e, int j);
    if (e == 0) begin
      return one ? p[2][j] : p[1][j];
    end
    return p[2][j];
  endfunction

  function automatic sort_t cswap01(sort_t s);
    sort_t r;
    r = s;
    if ($signed(s.d[0]) > $signed(s.d[1])) begin
      r.d[0]   = s.d[1];
      r.d[1]   = s.d[0];
      r.pts[0] = s.pts[1];
      r.pts[1] = s.pts[0];
    end
    return r;
  endfunction

  function automatic sort_t cswap12(sort_t s);
    sort_t r;
    r = s;
    if ($signed(s.d[1]) > $signed(s.d[2])) begin
      r.d[1]   = s.d[2];
      r.d[2]   = s.d[1];
      r.pts[1] = s.pts[2];
      r.pts[2] = s.pts[1];
    end
    return r;
  endfunction

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nx_r <= '0;
      ny_r <= '0;
      nz_r <= tpc_pkg::NORMAL_Z_RESET;
      k_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        tpc_pkg::REG_NORMAL_X:       nx_r <= cfg_data[31:0];
        tpc_pkg::REG_NORMAL_Y:       ny_r <= cfg_data[31:0];
        tpc_pkg::REG_NORMAL_Z:       nz_r <= cfg_data[31:0];
        tpc_pkg::REG_PLANE_CONSTANT: k_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the whole pipe unless the held record is still going out
  assign en       = !rec_valid_r || rec_done;
  assign in_stall = !en;

  // Stage 1: component products
  always_comb begin
    pts_in[0] = {in_data.corner0_w, in_data.corner0_z, in_data.corner0_y, in_data.corner0_x};
    pts_in[1] = {in_data.corner1_w, in_data.corner1_z, in_data.corner1_y, in_data.corner1_x};
    pts_in[2] = {in_data.corner2_w, in_data.corner2_z, in_data.corner2_y, in_data.corner2_x};
    for (int i = 0; i < 3; i++) begin
      prod_nxt[i][0] = $signed(pts_in[i][0]) * $signed(nx_r);
      prod_nxt[i][1] = $signed(pts_in[i][1]) * $signed(ny_r);
      prod_nxt[i][2] = $signed(pts_in[i][2]) * $signed(nz_r);
    end
  end

  // Stage 2 dot sums, stages 3 to 5 stable compare-swap sort
  always_comb begin
    srt_nxt[0].pts = s1_pts_r;
    for (int i = 0; i < 3; i++) begin
      srt_nxt[0].d[i] = tpc_pkg::DOT_W'(s1_prod_r[i][0]) + tpc_pkg::DOT_W'(s1_prod_r[i][1])
                      + tpc_pkg::DOT_W'(s1_prod_r[i][2]);
    end
    srt_nxt[1] = cswap01(srt_r[0]);
    srt_nxt[2] = cswap12(srt_r[1]);
    srt_nxt[3] = cswap01(srt_r[2]);
  end

  // Stage 6: classify against the plane, form edge numerators and divisors
  always_comb begin
    k_ext     = tpc_pkg::DOT_W'(k_r);
    d0        = $signed(srt_r[3].d[0]);
    d1        = $signed(srt_r[3].d[1]);
    d2        = $signed(srt_r[3].d[2]);
    one_above = d1 < k_ext;
    cls_nxt.pts = srt_r[3].pts;
    if (d2 <= k_ext) begin
      cls_nxt.code = tpc_pkg::CASE_NONE;
    end else if (d0 >= k_ext) begin
      cls_nxt.code = tpc_pkg::CASE_ALL;
    end else if (one_above) begin
      cls_nxt.code = tpc_pkg::CASE_ONE;
    end else begin
      cls_nxt.code = tpc_pkg::CASE_SPLIT;
    end
    num_nxt[0] = tpc_pkg::DIFF_W'(k_ext) - tpc_pkg::DIFF_W'(d0);
    den_nxt[0] = (one_above ? tpc_pkg::DIFF_W'(d2) : tpc_pkg::DIFF_W'(d1))
               - tpc_pkg::DIFF_W'(d0);
    num_nxt[1] = tpc_pkg::DIFF_W'(k_ext)
               - (one_above ? tpc_pkg::DIFF_W'(d1) : tpc_pkg::DIFF_W'(d0));
    den_nxt[1] = tpc_pkg::DIFF_W'(d2)
               - (one_above ? tpc_pkg::DIFF_W'(d1) : tpc_pkg::DIFF_W'(d0));
  end

  // Edge fractions
  tpc_div u_div0 (
    .clk (clk),
    .en  (en),
    .num (num_r[0]),
    .den (den_r[0]),
    .t   (t_edge[0])
  );

  tpc_div u_div1 (
    .clk (clk),
    .en  (en),
    .num (num_r[1]),
    .den (den_r[1]),
    .t   (t_edge[1])
  );

  // Interpolation stage 1: edge span magnitude and sign
  always_comb begin
    for (int e = 0; e < 2; e++) begin
      for (int j = 0; j < 4; j++) begin
        logic signed [32:0] diff;
        diff = 33'($signed(end_c(car_r[tpc_pkg::DIV_STAGES-1].pts,
                                 car_r[tpc_pkg::DIV_STAGES-1].code == tpc_pkg::CASE_ONE, e, j)))
             - 33'($signed(end_a(car_r[tpc_pkg::DIV_STAGES-1].pts,
                                 car_r[tpc_pkg::DIV_STAGES-1].code == tpc_pkg::CASE_ONE, e, j)));
        neg_nxt[e][j] = diff[32];
        mag_nxt[e][j] = diff[32] ? 33'(-diff) : 33'(diff);
      end
    end
  end

  // Interpolation stage 3: a plus truncated span times fraction, exact c at one
  always_comb begin
    rec_nxt.pts  = m2_r.pts;
    rec_nxt.code = m2_r.code;
    rec_nxt.e0   = '0;
    rec_nxt.e1   = '0;
    for (int e = 0; e < 2; e++) begin
      for (int j = 0; j < 4; j++) begin
        logic [33:0]   q;
        logic [33:0]   sum;
        tpc_pkg::q16_t a;
        tpc_pkg::q16_t c;
        tpc_pkg::q16_t res;
        a   = end_a(m2_r.pts, m2_r.code == tpc_pkg::CASE_ONE, e, j);
        c   = end_c(m2_r.pts, m2_r.code == tpc_pkg::CASE_ONE, e, j);
        q   = 34'(m2_hi_r[e][j] ? m2_t_r[e] : '0) + 34'(m2_prod_r[e][j][64:32]);
        sum = m2_neg_r[e][j] ? ({{2{a[31]}}, a} - q) : ({{2{a[31]}}, a} + q);
        res = m2_t_r[e][32] ? c : sum[31:0];
        if (e == 0) begin
          rec_nxt.e0[j] = res;
        end else begin
          rec_nxt.e1[j] = res;
        end
      end
    end
  end

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      cls_v_r <= 1'b0;
      m1_v_r  <= 1'b0;
      m2_v_r  <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        srt_v_r[i] <= 1'b0;
      end
      for (int i = 0; i < tpc_pkg::DIV_STAGES; i++) begin
        car_v_r[i] <= 1'b0;
      end
    end else if (en) begin
      s1_v_r     <= in_valid;
      srt_v_r[0] <= s1_v_r;
      for (int i = 1; i < 4; i++) begin
        srt_v_r[i] <= srt_v_r[i-1];
      end
      cls_v_r    <= srt_v_r[3];
      car_v_r[0] <= cls_v_r;
      for (int i = 1; i < tpc_pkg::DIV_STAGES; i++) begin
        car_v_r[i] <= car_v_r[i-1];
      end
      m1_v_r <= car_v_r[tpc_pkg::DIV_STAGES-1];
      m2_v_r <= m1_v_r;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (en) begin
      s1_pts_r  <= pts_in;
      s1_prod_r <= prod_nxt;
      for (int i = 0; i < 4; i++) begin
        srt_r[i] <= srt_nxt[i];
      end
      cls_r    <= cls_nxt;
      num_r    <= num_nxt;
      den_r    <= den_nxt;
      car_r[0] <= cls_r;
      for (int i = 1; i < tpc_pkg::DIV_STAGES; i++) begin
        car_r[i] <= car_r[i-1];
      end
      m1_r     <= car_r[tpc_pkg::DIV_STAGES-1];
      m1_mag_r <= mag_nxt;
      m1_neg_r <= neg_nxt;
      m1_t_r   <= t_edge;
      m2_r     <= m1_r;
      m2_t_r   <= m1_t_r;
      m2_neg_r <= m1_neg_r;
      for (int e = 0; e < 2; e++) begin
        for (int j = 0; j < 4; j++) begin
          m2_prod_r[e][j] <= m1_mag_r[e][j][31:0] * m1_t_r[e];
          m2_hi_r[e][j]   <= m1_mag_r[e][j][32];
        end
      end
      rec_r <= rec_nxt;
    end
  end

  // Pick the corner for the current output slot
  always_comb begin
    case (idx_r)
      3'd0:    sel = (rec_r.code == tpc_pkg::CASE_ALL) ? rec_r.pts[0] : rec_r.e0;
      3'd1:    sel = (rec_r.code == tpc_pkg::CASE_ALL) ? rec_r.pts[1] : rec_r.e1;
      3'd2:    sel = rec_r.pts[2];
      3'd3:    sel = rec_r.e0;
      3'd4:    sel = rec_r.pts[1];
      default: sel = rec_r.pts[2];
    endcase
    sel_last = (rec_r.code == tpc_pkg::CASE_SPLIT) ? (idx_r == IDX_LAST_SPLIT)
                                                   : (idx_r == IDX_LAST_ONE);
    out_nxt.out_x           = sel[0];
    out_nxt.out_y           = sel[1];
    out_nxt.out_z           = sel[2];
    out_nxt.out_w           = sel[3];
    out_nxt.triangle_number = idx_r >= IDX_SECOND;
    out_nxt.corner_number   = (idx_r >= IDX_SECOND) ? 2'(idx_r - IDX_SECOND) : idx_r[1:0];
    out_nxt.last            = sel_last;
  end

  // Send a corner when the output register is free; drop empty records
  assign out_ld   = rec_valid_r && (rec_r.code != tpc_pkg::CASE_NONE)
                 && (!out_valid_r || !out_stall);
  assign rec_done = rec_valid_r && ((rec_r.code == tpc_pkg::CASE_NONE) || (out_ld && sel_last));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_valid_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (en) begin
        rec_valid_r <= m2_v_r;
      end
      if (rec_done) begin
        idx_r <= '0;
      end else if (out_ld) begin
        idx_r <= idx_r + 3'd1;
      end
      if (out_ld) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `ASSERT_NEVER(a_idx_range, rec_valid_r && (idx_r > IDX_LAST_SPLIT), "output slot past end")
  `ASSERT_CLK(a_last_pos, out_valid_r && out_r.last |-> out_r.corner_number == 2'd2, "last not on third corner")
  `ASSERT_CLK(a_frac0_range, m1_v_r && (m1_r.code == tpc_pkg::CASE_ONE || m1_r.code == tpc_pkg::CASE_SPLIT) && m1_t_r[0][32] |-> m1_t_r[0][31:0] == '0, "edge 0 fraction above one")
  `ASSERT_CLK(a_frac1_range, m1_v_r && (m1_r.code == tpc_pkg::CASE_ONE || m1_r.code == tpc_pkg::CASE_SPLIT) && m1_t_r[1][32] |-> m1_t_r[1][31:0] == '0, "edge 1 fraction above one")

endmodule
